[rtl/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, codes and note tables of the buzzer melody sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_MODE    = 3'd1,
    OP_BEEP    = 3'd2,
    OP_BEEP_1K = 3'd3,
    OP_STOP    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_SIREN = 3'd2,
    MODE_GOAL  = 3'd3,
    MODE_BELL  = 3'd4,
    MODE_ALERT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_SIREN = 2'd1,
    SEL_BELL  = 2'd2,
    SEL_ALERT = 2'd3
  } sel_e;

  localparam logic [15:0] GOAL_HZ   = 16'd1500;
  localparam logic [15:0] GOAL_MS   = 16'd200;
  localparam logic [15:0] BEEP_1K_HZ = 16'd1000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  mode;
    logic [15:0] frequency;
    logic [15:0] duration;
  } item_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_frequency;
    logic        melody_active;
    logic [5:0]  note_index;
  } result_t;

  typedef struct packed {
    logic [15:0] hz;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } note_t;

  function automatic logic [5:0] mel_base(input logic [1:0] sel);
    logic [5:0] b;
    case (sel)
      SEL_BELL:  b = 6'd32;
      SEL_ALERT: b = 6'd34;
      default:   b = 6'd0;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] mel_len(input logic [1:0] sel);
    logic [5:0] l;
    case (sel)
      SEL_SIREN: l = 6'd32;
      SEL_BELL:  l = 6'd2;
      SEL_ALERT: l = 6'd3;
      default:   l = 6'd0;
    endcase
    return l;
  endfunction

  function automatic note_t note_rom(input logic [5:0] idx);
    note_t n;
    case (idx)
      6'd0, 6'd4:                 n = '{16'd523, 16'd500, 16'd0};
      6'd1, 6'd5:                 n = '{16'd392, 16'd500, 16'd0};
      6'd2, 6'd6:                 n = '{16'd440, 16'd500, 16'd0};
      6'd3, 6'd7:                 n = '{16'd494, 16'd500, 16'd0};
      6'd8, 6'd12:                n = '{16'd555, 16'd500, 16'd0};
      6'd9, 6'd13:                n = '{16'd408, 16'd500, 16'd0};
      6'd10, 6'd14:               n = '{16'd462, 16'd500, 16'd0};
      6'd11, 6'd15:               n = '{16'd523, 16'd500, 16'd0};
      6'd16:                      n = '{16'd587, 16'd500, 16'd0};
      6'd17:                      n = '{16'd440, 16'd500, 16'd0};
      6'd18:                      n = '{16'd494, 16'd500, 16'd0};
      6'd19:                      n = '{16'd555, 16'd500, 16'd0};
      6'd20:                      n = '{16'd587, 16'd400, 16'd0};
      6'd21:                      n = '{16'd440, 16'd400, 16'd0};
      6'd22:                      n = '{16'd494, 16'd400, 16'd0};
      6'd23:                      n = '{16'd555, 16'd400, 16'd0};
      6'd24:                      n = '{16'd587, 16'd2000, 16'd0};
      6'd25:                      n = '{16'd440, 16'd300, 16'd50};
      6'd26:                      n = '{16'd587, 16'd350, 16'd0};
      6'd27, 6'd29:               n = '{16'd738, 16'd250, 16'd250};
      6'd28:                      n = '{16'd880, 16'd500, 16'd500};
      6'd30:                      n = '{16'd880, 16'd1000, 16'd1000};
      6'd31:                      n = '{16'd587, 16'd1500, 16'd0};
      6'd32:                      n = '{16'd1000, 16'd250, 16'd300};
      6'd33:                      n = '{16'd1000, 16'd250, 16'd0};
      6'd34, 6'd35:               n = '{16'd2500, 16'd80, 16'd80};
      6'd36:                      n = '{16'd2500, 16'd80, 16'd0};
      default:                    n = '{16'd0, 16'd0, 16'd0};
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/bms_in_if.sv]
// ----------------------------------------------------------------------------
// bms_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  mode;
  logic [15:0] frequency;
  logic [15:0] duration;

  modport source (output valid, opcode, mode, frequency, duration, input ready);
  modport sink   (input valid, opcode, mode, frequency, duration, output ready);
endinterface

`default_nettype wire

[rtl/bms_out_if.sv]
// ----------------------------------------------------------------------------
// bms_out_if
// Result channel: one status word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bms_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_frequency;
  logic        melody_active;
  logic [5:0]  note_index;

  modport source (output valid, tone_on, tone_frequency, melody_active, note_index,
                  input ready);
  modport sink   (input valid, tone_on, tone_frequency, melody_active, note_index,
                  output ready);
endinterface

`default_nettype wire

[rtl/buzzer_melody_sequencer.sv]
// Path: a word is captured in the input register, then its result word in the result register.
// Throughput: one word per cycle; while a finished result waits, the input register
// takes one more word and then the input stalls until the result is taken.
// Reset: synchronous, active low; clears the time counter, tone, melody, pending
// mode, the enable register and both valid flags.
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer
// Buzzer tone controller: ticks, mode requests, timed beeps and melody tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buzzer_melody_sequencer #(
  parameter int TIME_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  bms_in_if.sink    in_chan,
  bms_out_if.source out_chan
);
  import bms_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_ready;

  bms_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  bms_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_chan   (out_chan)
  );

`ifndef SYNTHESIS
  a_silent_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.tone_on) |-> (out_chan.tone_frequency == 16'd0))
    else $error("tone frequency nonzero while tone is off");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.melody_active) |-> (out_chan.note_index == 6'd0))
    else $error("note index nonzero without a melody");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.note_index <= 6'd32))
    else $error("note index past the longest table");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while result side takes words");
`endif

endmodule

`default_nettype wire

[rtl/bms_in_reg.sv]
// ----------------------------------------------------------------------------
// bms_in_reg
// Input register: captures one command word and holds it for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bms_in_if.sink             in_chan,
  output bms_pkg::item_t     item,
  output logic               item_valid,
  input  wire logic          item_ready
);
  import bms_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_chan.ready = !valid_r || item_ready;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{opcode: in_chan.opcode, mode: in_chan.mode,
                  frequency: in_chan.frequency, duration: in_chan.duration};
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

[rtl/bms_engine.sv]
// ----------------------------------------------------------------------------
// bms_engine
// Tone state, melody stepping, result register; one word per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_engine #(
  parameter int TIME_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire bms_pkg::item_t item,
  input  wire logic          item_valid,
  output logic               item_ready,
  bms_out_if.source          out_chan
);
  import bms_pkg::*;

  logic                 enabled_r;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 beep_r, beep_nxt;
  logic [TIME_BITS-1:0] beep_dl_r, beep_dl_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic [5:0]           pos_r, pos_nxt;
  logic [TIME_BITS-1:0] mel_dl_r, mel_dl_nxt;
  logic                 sounding_r, sounding_nxt;
  logic [2:0]           pend_r, pend_nxt;
  logic                 tone_r, tone_nxt;
  logic [15:0]          freq_r, freq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              res_r, res_nxt;
  logic                 fire;
  logic                 pass_done;
  logic [TIME_BITS-1:0] now_tick;
  note_t                note;

  assign item_ready = !out_valid_r || out_chan.ready;
  assign fire       = item_valid && item_ready;
  assign now_tick   = now_r + TIME_BITS'(1);
  assign note       = note_rom(6'(mel_base(sel_r) + pos_r));

  always_comb begin
    now_nxt      = now_r;
    beep_nxt     = beep_r;
    beep_dl_nxt  = beep_dl_r;
    sel_nxt      = sel_r;
    pos_nxt      = pos_r;
    mel_dl_nxt   = mel_dl_r;
    sounding_nxt = sounding_r;
    pend_nxt     = pend_r;
    tone_nxt     = tone_r;
    freq_nxt     = freq_r;
    pass_done    = 1'b0;
    if (fire && enabled_r) begin
      case (item.opcode)
        OP_TICK: begin
          now_nxt = now_tick;
          // lone beep expires only while no melody plays
          if (beep_r && sel_r == SEL_NONE && now_tick >= beep_dl_r) begin
            tone_nxt = 1'b0;
            beep_nxt = 1'b0;
          end
          if (sel_r != SEL_NONE && now_tick >= mel_dl_r) begin
            if (pos_r >= mel_len(sel_r)) begin
              // melody over: drop tone, skip the pending check
              tone_nxt  = 1'b0;
              sel_nxt   = SEL_NONE;
              pass_done = 1'b1;
            end else if (!sounding_r) begin
              tone_nxt     = 1'b1;
              freq_nxt     = note.hz;
              sounding_nxt = 1'b1;
              mel_dl_nxt   = now_tick + TIME_BITS'(note.on_ms);
            end else begin
              tone_nxt     = 1'b0;
              sounding_nxt = 1'b0;
              mel_dl_nxt   = now_tick + TIME_BITS'(note.off_ms);
              pos_nxt      = pos_r + 6'd1;
            end
          end
          if (!pass_done) begin
            case (pend_r)
              MODE_SIREN, MODE_BELL, MODE_ALERT: begin
                if (beep_nxt) begin
                  tone_nxt = 1'b0;
                  beep_nxt = 1'b0;
                end
                sel_nxt      = (pend_r == MODE_SIREN) ? SEL_SIREN :
                               (pend_r == MODE_BELL)  ? SEL_BELL : SEL_ALERT;
                pos_nxt      = '0;
                sounding_nxt = 1'b0;
                mel_dl_nxt   = now_tick;
                pend_nxt     = MODE_OFF;
              end
              MODE_GOAL: begin
                tone_nxt    = 1'b1;
                freq_nxt    = GOAL_HZ;
                beep_nxt    = 1'b1;
                beep_dl_nxt = now_tick + TIME_BITS'(GOAL_MS);
                pend_nxt    = MODE_OFF;
              end
              default: ;
            endcase
          end
        end
        OP_MODE: begin
          if (item.mode != MODE_OFF && item.mode != MODE_ON) begin
            if (beep_r) begin
              tone_nxt = 1'b0;
              beep_nxt = 1'b0;
            end
            sel_nxt = SEL_NONE;
          end
          pend_nxt = item.mode;
          if (item.mode == MODE_OFF) begin
            tone_nxt = 1'b0;
            beep_nxt = 1'b0;
          end
        end
        OP_BEEP, OP_BEEP_1K: begin
          tone_nxt    = 1'b1;
          freq_nxt    = (item.opcode == OP_BEEP) ? item.frequency : BEEP_1K_HZ;
          beep_nxt    = 1'b1;
          beep_dl_nxt = now_r + TIME_BITS'(item.duration);
        end
        OP_STOP: begin
          tone_nxt = 1'b0;
          beep_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.tone_on        = tone_nxt;
    res_nxt.tone_frequency = tone_nxt ? freq_nxt : 16'd0;
    res_nxt.melody_active  = (sel_nxt != SEL_NONE);
    res_nxt.note_index     = (sel_nxt != SEL_NONE) ? pos_nxt : 6'd0;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      now_r       <= '0;
      beep_r      <= 1'b0;
      beep_dl_r   <= '0;
      sel_r       <= SEL_NONE;
      pos_r       <= '0;
      mel_dl_r    <= '0;
      sounding_r  <= 1'b0;
      pend_r      <= MODE_OFF;
      tone_r      <= 1'b0;
      freq_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
      now_r       <= now_nxt;
      beep_r      <= beep_nxt;
      beep_dl_r   <= beep_dl_nxt;
      sel_r       <= sel_nxt;
      pos_r       <= pos_nxt;
      mel_dl_r    <= mel_dl_nxt;
      sounding_r  <= sounding_nxt;
      pend_r      <= pend_nxt;
      tone_r      <= tone_nxt;
      freq_r      <= freq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.tone_on        = res_r.tone_on;
  assign out_chan.tone_frequency = res_r.tone_frequency;
  assign out_chan.melody_active  = res_r.melody_active;
  assign out_chan.note_index     = res_r.note_index;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buzzer melody sequencer. A directed table covers
// field extremes, every command and mode, and the odd cases (disabled buzzer,
// mode off during a melody, a beep over a melody, unused modes and opcodes).
// Random command words with tick bursts follow, then one full alert melody.
// Status words are checked against typed rows or a cycle-free sequencer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bms_pkg::*;

  localparam int RAND_ITEMS = 80;
  localparam int IDLE_PCT = 38;
  localparam int DIR_ROWS = 27;
  localparam int DIR_ENABLE_ROW = 3;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST = 3'd7;

  localparam result_t SILENT = '0;

  // {hz, on_ms, off_ms} per note; siren at 0, bell at 32, alert at 34
  localparam logic [47:0] SONG [37] = '{
    {16'd523, 16'd500, 16'd0}, {16'd392, 16'd500, 16'd0},
    {16'd440, 16'd500, 16'd0}, {16'd494, 16'd500, 16'd0},
    {16'd523, 16'd500, 16'd0}, {16'd392, 16'd500, 16'd0},
    {16'd440, 16'd500, 16'd0}, {16'd494, 16'd500, 16'd0},
    {16'd555, 16'd500, 16'd0}, {16'd408, 16'd500, 16'd0},
    {16'd462, 16'd500, 16'd0}, {16'd523, 16'd500, 16'd0},
    {16'd555, 16'd500, 16'd0}, {16'd408, 16'd500, 16'd0},
    {16'd462, 16'd500, 16'd0}, {16'd523, 16'd500, 16'd0},
    {16'd587, 16'd500, 16'd0}, {16'd440, 16'd500, 16'd0},
    {16'd494, 16'd500, 16'd0}, {16'd555, 16'd500, 16'd0},
    {16'd587, 16'd400, 16'd0}, {16'd440, 16'd400, 16'd0},
    {16'd494, 16'd400, 16'd0}, {16'd555, 16'd400, 16'd0},
    {16'd587, 16'd2000, 16'd0}, {16'd440, 16'd300, 16'd50},
    {16'd587, 16'd350, 16'd0},
    {16'd738, 16'd250, 16'd250}, {16'd880, 16'd500, 16'd500},
    {16'd738, 16'd250, 16'd250},
    {16'd880, 16'd1000, 16'd1000}, {16'd587, 16'd1500, 16'd0},
    {16'd1000, 16'd250, 16'd300}, {16'd1000, 16'd250, 16'd0},
    {16'd2500, 16'd80, 16'd80}, {16'd2500, 16'd80, 16'd80},
    {16'd2500, 16'd80, 16'd0}
  };
  localparam int MEL_BASE [4] = '{0, 0, 32, 34};
  localparam int MEL_LEN [4] = '{0, 32, 2, 3};

  typedef struct {
    item_t   word;
    bit      known;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bms_in_if in_chan ();
  bms_out_if out_chan ();

  buzzer_melody_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // sequencer model state
  bit          en;
  logic [31:0] t_now;
  bit          beep_on;
  logic [31:0] beep_due;
  sel_e        mel_sel;
  logic [5:0]  mel_pos;
  logic [31:0] mel_due;
  bit          note_live;
  logic [2:0]  queued_mode;
  bit          tone_live;
  logic [15:0] tone_hz;

  result_t status_q [$];
  int      mismatches = 0;
  int      items_sent = 0;
  bit      no_gaps = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // buzzer disabled: nothing moves
    '{'{OP_BEEP_1K, MODE_OFF, 16'h0000, 16'hFFFF}, 1'b1, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b1, SILENT},
    '{'{OP_MODE, MODE_ALERT, 16'hFFFF, 16'h0000}, 1'b1, SILENT},
    // enabled from here
    '{'{OP_BEEP, MODE_OFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 6'd0}},
    '{'{OP_STOP, MODE_OFF, 16'h0000, 16'h0000}, 1'b1, SILENT},
    '{'{OP_BEEP, MODE_OFF, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h0000, 1'b0, 6'd0}},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_BEEP_1K, MODE_OFF, 16'h1234, 16'd2}, 1'b1, '{1'b1, BEEP_1K_HZ, 1'b0, 6'd0}},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_GOAL, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_ON, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_ALERT, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    // off while a note sounds: tone drops, melody keeps its place
    '{'{OP_MODE, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_BEEP, MODE_OFF, 16'd777, 16'd5}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_SPARE_FIRST, 16'hFFFF, 16'hFFFF}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_UNUSED_FIRST, MODE_SPARE_LAST, 16'hFFFF, 16'hFFFF}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_BELL, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_MODE, MODE_SIREN, 16'h0000, 16'h0000}, 1'b0, SILENT},
    '{'{OP_TICK, MODE_OFF, 16'h0000, 16'h0000}, 1'b0, SILENT}
  };

  function automatic void silence_beep();
    tone_live = 1'b0;
    beep_on = 1'b0;
  endfunction

  function automatic void start_beep(input logic [15:0] hz, input logic [15:0] ms);
    tone_live = 1'b1;
    tone_hz = hz;
    beep_on = 1'b1;
    beep_due = t_now + 32'(ms);
  endfunction

  function automatic void load_melody(input sel_e sel);
    if (beep_on) silence_beep();
    mel_sel = sel;
    mel_pos = '0;
    note_live = 1'b0;
    mel_due = t_now;
  endfunction

  function automatic result_t next_status(input item_t w);
    result_t     r;
    bit          melody_over;
    int          nidx;
    logic [47:0] note;
    melody_over = 1'b0;
    if (en) begin
      case (w.opcode)
        OP_TICK: begin
          t_now = t_now + 32'd1;
          if (beep_on && mel_sel == SEL_NONE && t_now >= beep_due) silence_beep();
          if (mel_sel != SEL_NONE && t_now >= mel_due) begin
            if (int'(mel_pos) >= MEL_LEN[mel_sel]) begin
              // past the last note: end the melody and skip the rest of the pass
              tone_live = 1'b0;
              mel_sel = SEL_NONE;
              melody_over = 1'b1;
            end else begin
              nidx = MEL_BASE[mel_sel] + int'(mel_pos);
              note = SONG[nidx];
              if (!note_live) begin
                tone_live = 1'b1;
                tone_hz = note[47:32];
                note_live = 1'b1;
                mel_due = t_now + 32'(note[31:16]);
              end else begin
                tone_live = 1'b0;
                note_live = 1'b0;
                mel_due = t_now + 32'(note[15:0]);
                mel_pos = mel_pos + 6'd1;
              end
            end
          end
          if (!melody_over) begin
            case (queued_mode)
              MODE_SIREN: begin
                load_melody(SEL_SIREN);
                queued_mode = MODE_OFF;
              end
              MODE_GOAL: begin
                start_beep(GOAL_HZ, GOAL_MS);
                queued_mode = MODE_OFF;
              end
              MODE_BELL: begin
                load_melody(SEL_BELL);
                queued_mode = MODE_OFF;
              end
              MODE_ALERT: begin
                load_melody(SEL_ALERT);
                queued_mode = MODE_OFF;
              end
              default: ;
            endcase
          end
        end
        OP_MODE: begin
          if (w.mode != MODE_OFF && w.mode != MODE_ON) begin
            if (beep_on) silence_beep();
            mel_sel = SEL_NONE;
          end
          queued_mode = w.mode;
          if (w.mode == MODE_OFF) silence_beep();
        end
        OP_BEEP: start_beep(w.frequency, w.duration);
        OP_BEEP_1K: start_beep(BEEP_1K_HZ, w.duration);
        OP_STOP: silence_beep();
        default: ;
      endcase
    end
    r.tone_on = tone_live;
    r.tone_frequency = tone_live ? tone_hz : 16'd0;
    r.melody_active = (mel_sel != SEL_NONE);
    r.note_index = (mel_sel != SEL_NONE) ? mel_pos : 6'd0;
    return r;
  endfunction

  function automatic item_t rand_word(input logic [2:0] op);
    item_t w;
    w.opcode = op;
    w.mode = 3'($urandom_range(7));
    w.frequency = 16'($urandom_range(16'hFFFF));
    w.duration = 16'($urandom_range(16'hFFFF));
    return w;
  endfunction

  task automatic send_word(input item_t w);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= w.opcode;
    in_chan.mode <= w.mode;
    in_chan.frequency <= w.frequency;
    in_chan.duration <= w.duration;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    status_q.push_back(next_status(w));
    items_sent++;
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    drain_results();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    en = v;
  endtask

  always #5 clk = ~clk;

  // result side: random back-pressure, check each accepted status word
  always @(posedge clk) begin : status_sink
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.tone_on, out_chan.tone_frequency, out_chan.melody_active,
                out_chan.note_index};
        if (status_q.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected status word: expected none, got tone_on=%0d ",
                    "hz=%0d melody=%0d note=%0d"},
                   $time, got.tone_on, got.tone_frequency, got.melody_active,
                   got.note_index);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: status mismatch: expected tone_on=%0d hz=%0d melody=%0d ",
                      "note=%0d, got tone_on=%0d hz=%0d melody=%0d note=%0d"},
                     $time, want.tone_on, want.tone_frequency, want.melody_active,
                     want.note_index, got.tone_on, got.tone_frequency,
                     got.melody_active, got.note_index);
          end
        end
      end
      out_chan.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    item_t w;
    int    burst;
    int    pick;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_TICK;
    in_chan.mode = MODE_OFF;
    in_chan.frequency = '0;
    in_chan.duration = '0;
    out_chan.ready = 1'b0;
    en = 1'b0;
    t_now = '0;
    beep_on = 1'b0;
    beep_due = '0;
    mel_sel = SEL_NONE;
    mel_pos = '0;
    mel_due = '0;
    note_live = 1'b0;
    queued_mode = MODE_OFF;
    tone_live = 1'b0;
    tone_hz = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_ENABLE_ROW) write_enable(1'b1);
      send_word(dir_rows[i].word);
      // typed rows override the model's answer
      if (dir_rows[i].known) status_q[status_q.size() - 1] = dir_rows[i].want;
    end

    // random commands, each followed by a burst of ticks with some random words
    while (items_sent < RAND_ITEMS) begin
      w = rand_word(OP_TICK);
      burst = $urandom_range(4);
      pick = $urandom_range(99);
      if (pick < 20) begin
        w.opcode = OP_MODE;
        w.mode = (pick < 2) ? MODE_SIREN : ((pick < 11) ? MODE_BELL : MODE_ALERT);
        burst = $urandom_range(1) ? $urandom_range(30) : $urandom_range(8);
      end else if (pick < 30) begin
        w.opcode = OP_MODE;
        w.mode = MODE_GOAL;
        burst = $urandom_range(20);
      end else if (pick < 60) begin
        w.opcode = (pick < 50) ? OP_BEEP : OP_BEEP_1K;
        if ($urandom_range(99) < 70) w.duration = 16'($urandom_range(10));
        burst = $urandom_range(12);
      end else if (pick < 70) begin
        w.opcode = OP_STOP;
      end else if (pick < 80) begin
        w.opcode = OP_MODE;
        w.mode = $urandom_range(1) ? MODE_ON : MODE_OFF;
      end else if (pick < 87) begin
        w.opcode = OP_MODE;
        w.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end else if (pick < 92) begin
        w.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
        w.opcode = 3'($urandom_range(7));
      end
      send_word(w);
      repeat (burst) begin
        if ($urandom_range(99) < 3) send_word(rand_word(3'($urandom_range(7))));
        else send_word(rand_word(OP_TICK));
      end
    end

    // play the alert to its end at full rate on both sides
    no_gaps = 1'b1;
    w = rand_word(OP_MODE);
    w.mode = MODE_ALERT;
    send_word(w);
    send_word(rand_word(OP_TICK));
    while (mel_sel != SEL_NONE) send_word(rand_word(OP_TICK));
    no_gaps = 1'b0;

    write_enable(1'b0);
    repeat (10) send_word(rand_word(3'($urandom_range(7))));
    write_enable(1'b1);
    repeat (10) send_word(rand_word(3'($urandom_range(7))));

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
